### rtl/rmm_pkg.sv
// Shared types and constants for the region mean and medoid block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package rmm_pkg;

    localparam int MAX_LABELS   = 1024;
    localparam int LABEL_BITS   = $clog2(MAX_LABELS);
    localparam int NUM_FEATURES = 3;
    localparam int FEATURE_BITS = 16;
    localparam int PIX_BITS     = 22;
    localparam int SUM_BITS     = FEATURE_BITS + PIX_BITS;
    localparam int DIST_BITS    = 2 * FEATURE_BITS + $clog2(NUM_FEATURES + 1);
    localparam int STEP_BITS    = $clog2(FEATURE_BITS + 1);

    localparam logic [1:0] REQ_ACC    = 2'd0;
    localparam logic [1:0] REQ_MEDOID = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    typedef logic [NUM_FEATURES-1:0][FEATURE_BITS-1:0] feat_vec_t;
    typedef logic [NUM_FEATURES-1:0][SUM_BITS-1:0]     sum_vec_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [LABEL_BITS-1:0] label;
        logic                  usable;
        logic [PIX_BITS-1:0]   pos;
        feat_vec_t             feats;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    typedef struct packed {
        logic pop;
        logic init_busy;
    } back_ctrl_t;

    typedef struct packed {
        sum_vec_t             sums;
        logic [PIX_BITS-1:0]  count;
        logic [DIST_BITS-1:0] distance;
        logic                 valid;
    } stat_row_t;

    typedef struct packed {
        logic [PIX_BITS-1:0] pos;
        feat_vec_t           feats;
    } med_row_t;

endpackage

### rtl/region_mean_and_medoid.sv
// Top level of the per-label mean and medoid block.
// Depends on rmm_pkg, rmm_front and rmm_back (which holds rmm_div).
`timescale 1ns / 1ps

// Gathers per-label feature sums and counts over a pixel stream, finds the
// pixel closest to each label's floor mean, and reports both on a read word.
// Words are taken one at a time by the back end behind a two-entry queue.
// A medoid candidate or a read of a usable, non-empty label runs the 16-step
// restoring divider that forms the three means in parallel; a read of an
// empty or unusable label skips the divider, and a read also waits out any
// output stall. A clear runs a sweep through all 1024 label rows of the
// store; after reset the same sweep runs and in_stall stays high until it
// ends. Only a read produces a result word; label zero reads as empty.
module region_mean_and_medoid
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [9:0]  label,
    input  logic [21:0] pixel_index,
    input  logic [15:0] feature_a,
    input  logic [15:0] feature_b,
    input  logic [15:0] feature_c,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] mean_a,
    output logic [15:0] mean_b,
    output logic [15:0] mean_c,
    output logic [21:0] region_size,
    output logic        region_empty,
    output logic        medoid_found,
    output logic [21:0] medoid_position,
    output logic [15:0] medoid_a,
    output logic [15:0] medoid_b,
    output logic [15:0] medoid_c
);

    rmm_pkg::item_t      in_item;
    rmm_pkg::head_t      head;
    rmm_pkg::back_ctrl_t ctrl;
    rmm_pkg::feat_vec_t  mean, mfeat;

    // Pack the request word; usable is filled in by the front end.
    always_comb
    begin
        in_item          = '0;
        in_item.kind     = req_type;
        in_item.label    = label;
        in_item.pos      = pixel_index;
        in_item.feats[0] = feature_a;
        in_item.feats[1] = feature_b;
        in_item.feats[2] = feature_c;
    end

    rmm_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .ctrl     (ctrl),
        .head     (head)
    );

    rmm_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .ctrl      (ctrl),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .mean      (mean),
        .size      (region_size),
        .empty     (region_empty),
        .found     (medoid_found),
        .mpos      (medoid_position),
        .mfeat     (mfeat)
    );

    assign mean_a   = mean[0];
    assign mean_b   = mean[1];
    assign mean_c   = mean[2];
    assign medoid_a = mfeat[0];
    assign medoid_b = mfeat[1];
    assign medoid_c = mfeat[2];

endmodule

### rtl/rmm_front.sv
// Front end: accepts request words, classifies the label and queues them.
// Depends on rmm_pkg.
`timescale 1ns / 1ps

module rmm_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rmm_pkg::item_t     in_item,
    input  rmm_pkg::back_ctrl_t ctrl,
    output rmm_pkg::head_t     head
);

    rmm_pkg::item_t q_reg [2];
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;
    logic           push;
    rmm_pkg::item_t cls;

    always_comb
    begin
        cls        = in_item;
        cls.usable = (in_item.label != '0) && (32'(in_item.label) < rmm_pkg::MAX_LABELS);
    end

    assign in_stall   = (cnt_reg == 2'd2) || ctrl.init_busy;
    assign push       = in_valid && !in_stall;
    assign head.valid = cnt_reg != 2'd0;
    assign head.item  = q_reg[0];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !ctrl.pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!push && ctrl.pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Two-entry queue; slot 0 is the head.
    always_ff @(posedge clk)
    begin
        if (push && cnt_next == 2'd1)
        begin
            q_reg[0] <= cls;
        end
        else if (ctrl.pop)
        begin
            q_reg[0] <= q_reg[1];
        end
        if (push && cnt_next != 2'd1)
        begin
            q_reg[1] <= cls;
        end
    end

endmodule

### rtl/rmm_div.sv
// Restoring divider lanes: each feature sum over the shared pixel count,
// one quotient bit per cycle. Depends on rmm_pkg.
`timescale 1ns / 1ps

module rmm_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  rmm_pkg::sum_vec_t             num,
    input  logic [rmm_pkg::PIX_BITS-1:0]  den,
    output logic                          done,
    output rmm_pkg::feat_vec_t            quo
);

    logic [rmm_pkg::NUM_FEATURES-1:0][rmm_pkg::PIX_BITS-1:0] rem_reg;
    rmm_pkg::feat_vec_t                 q_reg;
    logic [rmm_pkg::PIX_BITS-1:0]       den_reg;
    logic [rmm_pkg::STEP_BITS-1:0]      step_reg;
    logic                               busy_reg;
    logic                               done_reg;

    assign done = done_reg;
    assign quo  = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == rmm_pkg::STEP_BITS'(rmm_pkg::FEATURE_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The quotient fits the feature width, so the upper part of the sum
    // starts below the divisor.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            for (int f = 0; f < rmm_pkg::NUM_FEATURES; f++)
            begin
                rem_reg[f] <= num[f][rmm_pkg::SUM_BITS-1:rmm_pkg::FEATURE_BITS];
                q_reg[f]   <= num[f][rmm_pkg::FEATURE_BITS-1:0];
            end
        end
        else if (busy_reg)
        begin
            for (int f = 0; f < rmm_pkg::NUM_FEATURES; f++)
            begin
                if ({rem_reg[f], q_reg[f][rmm_pkg::FEATURE_BITS-1]} >= {1'b0, den_reg})
                begin
                    rem_reg[f] <= rmm_pkg::PIX_BITS'({rem_reg[f],
                                  q_reg[f][rmm_pkg::FEATURE_BITS-1]} - {1'b0, den_reg});
                    q_reg[f]   <= {q_reg[f][rmm_pkg::FEATURE_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[f] <= {rem_reg[f][rmm_pkg::PIX_BITS-2:0],
                                   q_reg[f][rmm_pkg::FEATURE_BITS-1]};
                    q_reg[f]   <= {q_reg[f][rmm_pkg::FEATURE_BITS-2:0], 1'b0};
                end
            end
        end
    end

endmodule

### rtl/rmm_back.sv
// Back end: label store, clearing sweep, mean division, distance compare
// and the result register. Depends on rmm_pkg and rmm_div.
`timescale 1ns / 1ps

module rmm_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  rmm_pkg::head_t       head,
    output rmm_pkg::back_ctrl_t  ctrl,
    output logic                 out_valid,
    input  logic                 out_stall,
    output rmm_pkg::feat_vec_t   mean,
    output logic [rmm_pkg::PIX_BITS-1:0] size,
    output logic                 empty,
    output logic                 found,
    output logic [rmm_pkg::PIX_BITS-1:0] mpos,
    output rmm_pkg::feat_vec_t   mfeat
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    rmm_pkg::stat_row_t stat_mem [rmm_pkg::MAX_LABELS];
    rmm_pkg::med_row_t  med_mem  [rmm_pkg::MAX_LABELS];

    logic [2:0]                     state_reg, state_next;
    logic                           sweep_reg, init_reg;
    logic [rmm_pkg::LABEL_BITS-1:0] cursor_reg;
    rmm_pkg::item_t                 cur_reg;
    rmm_pkg::stat_row_t             stat_q_reg;
    rmm_pkg::med_row_t              med_q_reg;
    logic [rmm_pkg::NUM_FEATURES-1:0][2*rmm_pkg::FEATURE_BITS-1:0] sq_reg;

    logic                           pop, div_start, div_done, last_sweep;
    rmm_pkg::feat_vec_t             quo;
    logic                           s_we, m_we, better, load_out;
    logic [rmm_pkg::LABEL_BITS-1:0] s_wa;
    rmm_pkg::stat_row_t             s_wd;
    logic [rmm_pkg::DIST_BITS-1:0]  cand_dist;
    logic                           cnt_zero, cnt_full;

    rmm_pkg::feat_vec_t             mean_reg, mfeat_reg;
    logic [rmm_pkg::PIX_BITS-1:0]   size_reg, mpos_reg;
    logic                           empty_reg, found_reg, out_valid_reg;

    assign cnt_zero   = stat_q_reg.count == '0;
    assign cnt_full   = stat_q_reg.count == '1;
    assign pop        = (state_reg == S_IDLE) && !sweep_reg && head.valid;
    assign last_sweep = cursor_reg == rmm_pkg::LABEL_BITS'(rmm_pkg::MAX_LABELS - 1);
    assign ctrl.pop       = pop;
    assign ctrl.init_busy = init_reg;

    rmm_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (stat_q_reg.sums),
        .den   (stat_q_reg.count),
        .done  (div_done),
        .quo   (quo)
    );

    always_comb
    begin
        cand_dist = '0;
        for (int f = 0; f < rmm_pkg::NUM_FEATURES; f++)
        begin
            cand_dist = cand_dist + rmm_pkg::DIST_BITS'(sq_reg[f]);
        end
    end
    assign better = !stat_q_reg.valid || (cand_dist < stat_q_reg.distance);

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_IDLE;
                if (cur_reg.kind == rmm_pkg::REQ_MEDOID && cur_reg.usable && !cnt_zero)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else if (cur_reg.kind == rmm_pkg::REQ_READ)
                begin
                    if (cur_reg.usable && !cnt_zero)
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = (cur_reg.kind == rmm_pkg::REQ_READ) ? S_OUT : S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_IDLE;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Store write port: sweep, accumulate or medoid update.
    always_comb
    begin
        s_we = 1'b0;
        m_we = 1'b0;
        s_wa = cur_reg.label;
        s_wd = stat_q_reg;
        if (sweep_reg)
        begin
            s_we           = 1'b1;
            s_wa           = cursor_reg;
            s_wd           = '0;
            s_wd.distance  = '1;
        end
        else if (state_reg == S_LOOK && cur_reg.kind == rmm_pkg::REQ_ACC
                 && cur_reg.usable && !cnt_full)
        begin
            s_we = 1'b1;
            for (int f = 0; f < rmm_pkg::NUM_FEATURES; f++)
            begin
                s_wd.sums[f] = stat_q_reg.sums[f] + rmm_pkg::SUM_BITS'(cur_reg.feats[f]);
            end
            s_wd.count = stat_q_reg.count + 1'b1;
        end
        else if (state_reg == S_CMP && better)
        begin
            s_we          = 1'b1;
            m_we          = 1'b1;
            s_wd.valid    = 1'b1;
            s_wd.distance = cand_dist;
        end
    end

    // Read the row of the popped word once and hold it for the whole word.
    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            stat_mem[s_wa] <= s_wd;
        end
        if (m_we)
        begin
            med_mem[cur_reg.label] <= '{pos: cur_reg.pos, feats: cur_reg.feats};
        end
        if (pop)
        begin
            stat_q_reg <= stat_mem[head.item.label];
            med_q_reg  <= med_mem[head.item.label];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head.item;
        end
        for (int f = 0; f < rmm_pkg::NUM_FEATURES; f++)
        begin
            if (cur_reg.feats[f] > quo[f])
            begin
                sq_reg[f] <= (cur_reg.feats[f] - quo[f]) * (cur_reg.feats[f] - quo[f]);
            end
            else
            begin
                sq_reg[f] <= (quo[f] - cur_reg.feats[f]) * (quo[f] - cur_reg.feats[f]);
            end
        end
        if (load_out)
        begin
            mean_reg  <= (cur_reg.usable && !cnt_zero) ? quo : '0;
            size_reg  <= cur_reg.usable ? stat_q_reg.count : '0;
            empty_reg <= !cur_reg.usable || cnt_zero;
            found_reg <= cur_reg.usable && stat_q_reg.valid;
            mpos_reg  <= (cur_reg.usable && stat_q_reg.valid) ? med_q_reg.pos : '0;
            mfeat_reg <= (cur_reg.usable && stat_q_reg.valid) ? med_q_reg.feats : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sweep_reg     <= 1'b1;
            init_reg      <= 1'b1;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (sweep_reg)
            begin
                cursor_reg <= cursor_reg + 1'b1;
                if (last_sweep)
                begin
                    sweep_reg <= 1'b0;
                    init_reg  <= 1'b0;
                end
            end
            else if (state_reg == S_LOOK && cur_reg.kind == rmm_pkg::REQ_CLEAR)
            begin
                sweep_reg  <= 1'b1;
                cursor_reg <= '0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign mean      = mean_reg;
    assign size      = size_reg;
    assign empty     = empty_reg;
    assign found     = found_reg;
    assign mpos      = mpos_reg;
    assign mfeat     = mfeat_reg;

endmodule
